### hdl/spe_pkg.sv
// Package: shared types, codes and fixed-point helpers for the surplus production step.
`default_nettype none
package spe_pkg;

  localparam int unsigned AccW = 96;
  localparam int unsigned DenW = 80;
  localparam int unsigned MagW = 48;
  localparam logic signed [32:0] OneQ24 = 33'sd16777216;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_OUT
  } st_e;

  typedef enum logic [3:0] {
    STP_B0,
    STP_P0,
    STP_Q,
    STP_G1,
    STP_G,
    STP_KA,
    STP_U,
    STP_T,
    STP_P,
    STP_M,
    STP_C,
    STP_R
  } stp_e;

  typedef struct packed {
    logic start;
    logic op_div;
    logic [AccW-1:0] num;
    logic [DenW-1:0] den;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic [AccW-1:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic sat;
    logic [47:0] val;
  } clp_t;

  function automatic logic [MagW-1:0] mag49(input logic signed [48:0] v);
    logic [48:0] m;
    begin
      m = v[48] ? 49'(-v) : 49'(v);
      return m[MagW-1:0];
    end
  endfunction

  function automatic clp_t clamp_mag(input logic [AccW-1:0] m, input logic neg,
                                     input logic w48);
    logic [AccW-1:0] lim;
    logic [AccW-1:0] v;
    clp_t r;
    begin
      lim = w48 ? (AccW'(1) << 47) : (AccW'(1) << 31);
      if (!neg) begin
        lim = lim - AccW'(1);
      end
      r.sat = (m > lim);
      v = r.sat ? lim : m;
      r.val = neg ? 48'(-v[47:0]) : v[47:0];
      return r;
    end
  endfunction

  function automatic clp_t sat48(input logic signed [49:0] v);
    clp_t r;
    begin
      r.sat = 1'b0;
      r.val = v[47:0];
      if (v > 50'sd140737488355327) begin
        r.sat = 1'b1;
        r.val = 48'h7FFF_FFFF_FFFF;
      end else if (v < -50'sd140737488355328) begin
        r.sat = 1'b1;
        r.val = 48'h8000_0000_0000;
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

### hdl/spe_if.sv
// Interfaces: input item, result item and configuration write channels.
`default_nettype none
interface spe_in_if;
  logic        valid;
  logic        ready;
  logic        first_year;
  logic [31:0] depletion_start;
  logic [46:0] carrying_capacity;
  logic [31:0] growth_rate;
  logic [31:0] effort_gain;
  logic [31:0] bionomic_ratio;
  logic [47:0] observed_catch;
  logic [15:0] year_label;
  modport source (output valid, first_year, depletion_start, carrying_capacity, growth_rate,
                  effort_gain, bionomic_ratio, observed_catch, year_label, input ready);
  modport sink (input valid, first_year, depletion_start, carrying_capacity, growth_rate,
                effort_gain, bionomic_ratio, observed_catch, year_label, output ready);
endinterface

interface spe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] ratio_to_bmsy;
  logic [47:0] biomass;
  logic [31:0] harvest_proportion;
  logic [47:0] predicted_catch;
  logic [47:0] catch_echo;
  logic [15:0] year_echo;
  logic        saturated;
  modport source (output valid, ratio_to_bmsy, biomass, harvest_proportion, predicted_catch,
                  catch_echo, year_echo, saturated, input ready);
  modport sink (input valid, ratio_to_bmsy, biomass, harvest_proportion, predicted_catch,
                catch_echo, year_echo, saturated, output ready);
endinterface

interface spe_cfg_if;
  logic valid;
  logic ready;
  logic logistic_mode;
  modport source (output valid, logistic_mode, input ready);
  modport sink (input valid, logistic_mode, output ready);
endinterface
`default_nettype wire

### hdl/spe_alu.sv
// Shared bit-serial unit: shift-add multiplier and restoring divider.
`default_nettype none
module spe_alu
  import spe_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire alu_req_t req_i,
  output alu_rsp_t      rsp_o
);

  logic            busy_q, done_q, div_q;
  logic [6:0]      cnt_q;
  logic [AccW-1:0] acc_q, nq_q;
  logic [MagW-1:0] mpl_q;
  logic [DenW-1:0] den_q;
  logic [AccW:0]   r2;
  logic            ge;
  logic [6:0]      last;

  assign r2   = {acc_q, nq_q[AccW-1]};
  assign ge   = r2 >= (AccW+1)'(den_q);
  assign last = div_q ? 7'(AccW - 1) : 7'(MagW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.op_div;
      den_q <= req_i.den;
      mpl_q <= req_i.den[MagW-1:0];
      acc_q <= '0;
      nq_q  <= req_i.num;
    end else if (busy_q) begin
      if (div_q) begin
        acc_q <= ge ? AccW'(r2 - (AccW+1)'(den_q)) : AccW'(r2);
        nq_q  <= {nq_q[AccW-2:0], ge};
      end else begin
        if (mpl_q[0]) begin
          acc_q <= acc_q + nq_q;
        end
        nq_q  <= {nq_q[AccW-2:0], 1'b0};
        mpl_q <= {1'b0, mpl_q[MagW-1:1]};
      end
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = div_q ? nq_q : acc_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("start while busy");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("busy ended without done");

endmodule
`default_nettype wire

### hdl/surplus_production_effort_step.sv
// Top level: Schaefer surplus production year step with effort dynamics.
//   channel | dir | beat contents
//   in_i    | in  | trajectory parameters, observed catch, year
//   out_o   | out | ratio to BMSY, biomass, proportion, catches, year, saturated
//   cfg_i   | in  | logistic_mode
// Each item runs a sequence of steps (fewer in a first year, more in logistic mode) on the
// one serial unit, each step being an issue, the serial work and a completion: a multiply
// covers a 48-bit multiplier and a divide develops a 96-bit quotient.
// Reset clears trajectory state and sets logistic mode.
// in_i.ready is low from accept until the result beat is taken; cfg_i is always ready.
`default_nettype none
module surplus_production_effort_step
  import spe_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spe_in_if.sink    in_i,
  spe_out_if.source out_o,
  spe_cfg_if.sink   cfg_i
);

  st_e  st_q, st_d;
  stp_e stp_q;
  logic mode_q;

  logic        first_q;
  logic [31:0] h_q, r_q, x_q, a_q;
  logic [46:0] k_q;
  logic [47:0] ct_q;
  logic [15:0] yr_q;

  logic [47:0] ob_q, lc_q, b_q, c_q, g1_q;
  logic [31:0] lp_q, ip_q, p_q, q_q, u_q, t_q, rt_q;
  logic [DenW-1:0] ka_q;
  logic sat_q;

  alu_req_t req;
  alu_rsp_t rsp;
  logic signed [48:0] opa, opb;
  logic nneg, dneg, neg, sh24, w48;
  logic [AccW-1:0] m;
  clp_t clp, s1, s2, s3;
  logic in_acc;

  spe_alu u_alu (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  assign in_acc = in_i.valid && in_i.ready;

  always_comb begin
    req.start  = (st_q == ST_ISSUE);
    req.op_div = 1'b0;
    req.num    = '0;
    req.den    = '0;
    opa  = '0;
    opb  = '0;
    nneg = 1'b0;
    dneg = 1'b0;
    sh24 = 1'b1;
    w48  = 1'b0;
    unique case (stp_q)
      STP_B0: begin
        opa = 49'(OneQ24 - 33'(signed'(h_q)));
        opb = 49'({2'b0, k_q});
        w48 = 1'b1;
      end
      STP_P0: begin
        req.op_div = 1'b1;
        req.num = AccW'(mag49(49'(signed'(ct_q)))) << 24;
        req.den = DenW'(mag49(49'(signed'(b_q))));
        nneg = ct_q[47];
        dneg = b_q[47];
      end
      STP_Q: begin
        req.op_div = 1'b1;
        req.num = AccW'(mag49(49'(signed'(ob_q)))) << 24;
        req.den = DenW'(k_q);
        nneg = ob_q[47];
      end
      STP_G1: begin
        opa = 49'(signed'(r_q));
        opb = 49'(signed'(ob_q));
        w48 = 1'b1;
      end
      STP_G: begin
        opa = 49'(signed'(g1_q));
        opb = 49'(OneQ24 - 33'(signed'(q_q)));
        w48 = 1'b1;
      end
      STP_KA: begin
        opa  = 49'({2'b0, k_q});
        opb  = 49'(mag49(49'(signed'(a_q))));
        sh24 = 1'b0;
      end
      STP_U: begin
        req.op_div = 1'b1;
        req.num = AccW'(mag49(49'(signed'(ob_q)))) << 48;
        req.den = ka_q;
        nneg = ob_q[47];
        dneg = a_q[31];
      end
      STP_T: begin
        opa = 49'(signed'(x_q));
        opb = 49'(33'(signed'(u_q)) - OneQ24);
      end
      STP_P: begin
        opa = 49'(signed'(lp_q));
        opb = 49'(OneQ24 + 33'(signed'(t_q)));
      end
      STP_M: begin
        opa = 49'(signed'(x_q));
        opb = 49'(signed'(ip_q));
      end
      STP_C: begin
        opa = 49'(signed'(b_q));
        opb = 49'(signed'(p_q));
        w48 = 1'b1;
      end
      STP_R: begin
        req.op_div = 1'b1;
        req.num = AccW'(mag49(49'(signed'(b_q)))) << 25;
        req.den = DenW'(k_q);
        nneg = b_q[47];
      end
      default: begin
      end
    endcase
    if (!req.op_div) begin
      req.num = AccW'(mag49(opa));
      req.den = DenW'(mag49(opb));
      nneg = opa[48];
      dneg = opb[48];
    end
    if (req.op_div) begin
      sh24 = 1'b0;
    end
    neg = (req.op_div && req.den == '0) ? nneg : (nneg ^ dneg);
    m   = sh24 ? (rsp.res >> 24) : rsp.res;
    clp = clamp_mag(m, neg, w48);
    s1  = sat48(50'(signed'(ob_q)) + 50'(signed'(clp.val)));
    s2  = sat48(50'(signed'(s1.val)) - 50'(signed'(lc_q)));
    s3  = sat48(50'(signed'(lp_q)) + 50'(signed'(clp.val[31:0])));
    if (s3.val[47:31] != 17'h0 && s3.val[47:31] != 17'h1FFFF) begin
      s3.sat = 1'b1;
      s3.val = s3.val[47] ? 48'hFFFF_8000_0000 : 48'h0000_7FFF_FFFF;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:  if (in_i.valid) st_d = ST_ISSUE;
      ST_ISSUE: st_d = ST_WAIT;
      ST_WAIT: begin
        if (rsp.done) st_d = (stp_q == STP_R) ? ST_OUT : ST_ISSUE;
      end
      ST_OUT:   if (out_o.ready) st_d = ST_IDLE;
      default:  st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready  = (st_q == ST_IDLE);
    out_o.valid = (st_q == ST_OUT);
    cfg_i.ready = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      stp_q  <= STP_B0;
      mode_q <= 1'b1;
      ob_q   <= '0;
      lp_q   <= '0;
      lc_q   <= '0;
      ip_q   <= '0;
      sat_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= cfg_i.logistic_mode;
      end
      if (in_acc) begin
        stp_q <= in_i.first_year ? STP_B0 : STP_Q;
        sat_q <= 1'b0;
      end else if (st_q == ST_WAIT && rsp.done) begin
        if (stp_q != STP_KA) begin
          sat_q <= sat_q | clp.sat | ((stp_q == STP_G) && (s1.sat || s2.sat))
                   | ((stp_q == STP_M) && s3.sat);
        end
        unique case (stp_q)
          STP_B0: stp_q <= STP_P0;
          STP_P0: begin
            stp_q <= STP_R;
            ip_q  <= clp.val[31:0];
          end
          STP_Q:  stp_q <= STP_G1;
          STP_G1: stp_q <= STP_G;
          STP_G:  stp_q <= mode_q ? STP_KA : STP_M;
          STP_KA: stp_q <= STP_U;
          STP_U:  stp_q <= STP_T;
          STP_T:  stp_q <= STP_P;
          STP_P:  stp_q <= STP_C;
          STP_M:  stp_q <= STP_C;
          STP_C:  stp_q <= STP_R;
          STP_R: begin
            ob_q <= b_q;
            lp_q <= p_q;
            lc_q <= c_q;
          end
          default: stp_q <= STP_R;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      first_q <= in_i.first_year;
      h_q  <= in_i.depletion_start;
      k_q  <= in_i.carrying_capacity;
      r_q  <= in_i.growth_rate;
      x_q  <= in_i.effort_gain;
      a_q  <= in_i.bionomic_ratio;
      ct_q <= in_i.observed_catch;
      yr_q <= in_i.year_label;
      c_q  <= in_i.observed_catch;
    end else if (st_q == ST_WAIT && rsp.done) begin
      unique case (stp_q)
        STP_B0: b_q  <= clp.val;
        STP_P0: p_q  <= clp.val[31:0];
        STP_Q:  q_q  <= clp.val[31:0];
        STP_G1: g1_q <= clp.val;
        STP_G:  b_q  <= s2.val;
        STP_KA: ka_q <= rsp.res[DenW-1:0];
        STP_U:  u_q  <= clp.val[31:0];
        STP_T:  t_q  <= clp.val[31:0];
        STP_P:  p_q  <= clp.val[31:0];
        STP_M:  p_q  <= s3.val[31:0];
        STP_C:  c_q  <= clp.val;
        STP_R:  rt_q <= clp.val[31:0];
        default: rt_q <= clp.val[31:0];
      endcase
    end
  end

  assign out_o.ratio_to_bmsy      = rt_q;
  assign out_o.biomass            = b_q;
  assign out_o.harvest_proportion = p_q;
  assign out_o.predicted_catch    = c_q;
  assign out_o.catch_echo         = ct_q;
  assign out_o.year_echo          = yr_q;
  assign out_o.saturated          = sat_q;

  a_first_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_WAIT && rsp.done && stp_q == STP_B0) |-> first_q) else $error("first path");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> st_q == ST_ISSUE) else $error("accept did not start");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(stp_q) == STP_R) else $error("early result");

endmodule
`default_nettype wire
